FILE: rtl/tlbrr_pkg.sv
// Package for the fully associative translation buffer with round-robin replacement.
// Holds the command codes, the per-cell control token type and the default sizes.
// No dependencies.
package tlbrr_pkg;

	// Default sizes of the buffer.
	localparam int DEF_ENTRIES    = 16;
	localparam int DEF_PAGE_BITS  = 16;
	localparam int DEF_FRAME_BITS = 16;

	// Widths of the page and frame fields on the ports.
	localparam int IO_PAGE_W  = 16;
	localparam int IO_FRAME_W = 16;

	// Command codes; the fourth code is unused and changes nothing.
	localparam logic [1:0] CMD_LOOKUP     = 2'd0;
	localparam logic [1:0] CMD_INSERT     = 2'd1;
	localparam logic [1:0] CMD_INVALIDATE = 2'd2;

	// Control part of the token that walks down the row of cells.
	typedef struct packed {
		logic       vld;
		logic [1:0] cmd;
		logic       mark;
		logic       found;
	} tok_ctl_t;

endpackage

FILE: rtl/tlbrr_cell.sv
// One slot of the translation buffer: holds page, frame and valid mark, and
// processes the item token as it passes, then hands it on to the next slot.
// Depends on tlbrr_pkg.
module tlbrr_cell #(
	parameter int PAGE_BITS  = 16,
	parameter int FRAME_BITS = 16,
	parameter int IDX_W      = 4,
	parameter int INDEX      = 0
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  tlbrr_pkg::tok_ctl_t     ctl_in,
	input  logic [PAGE_BITS-1:0]    page_in,
	input  logic [FRAME_BITS-1:0]   frame_in,
	input  logic [IDX_W-1:0]        victim_in,
	output tlbrr_pkg::tok_ctl_t     ctl_out,
	output logic [PAGE_BITS-1:0]    page_out,
	output logic [FRAME_BITS-1:0]   frame_out,
	output logic [IDX_W-1:0]        victim_out
);
	import tlbrr_pkg::*;

	logic [PAGE_BITS-1:0]  page_q;
	logic [FRAME_BITS-1:0] frame_q;
	logic                  valid_q;

	tok_ctl_t              ctl_q;
	tok_ctl_t              ctl_nxt;
	logic [PAGE_BITS-1:0]  tok_page_q;
	logic [FRAME_BITS-1:0] tok_frame_q;
	logic [IDX_W-1:0]      tok_victim_q;

	logic page_match;
	logic frame_match;
	logic do_lookup;
	logic do_insert;
	logic do_inval;

	// Local compares against the held entry; only a valid entry can match.
	assign page_match  = valid_q && (page_q == page_in);
	assign frame_match = valid_q && (frame_q == frame_in);
	assign do_lookup   = ctl_in.vld && (ctl_in.cmd == CMD_LOOKUP) && !ctl_in.found
		&& page_match;
	assign do_insert   = ctl_in.vld && (ctl_in.cmd == CMD_INSERT)
		&& (victim_in == IDX_W'(INDEX));
	assign do_inval    = ctl_in.vld && (ctl_in.cmd == CMD_INVALIDATE) && !ctl_in.found
		&& frame_match;

	// The valid mark is cleared at reset; an insert writes it from the token's mark, an invalidate clears it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (do_insert) begin
			valid_q <= ctl_in.mark;
		end else if (do_inval) begin
			valid_q <= 1'b0;
		end
	end

	// Page and frame are written by an insert only.
	always_ff @(posedge clk) begin
		if (do_insert) begin
			page_q  <= page_in;
			frame_q <= frame_in;
		end
	end

	// Next token control: the first matching slot claims the item for later slots.
	always_comb begin
		ctl_nxt       = ctl_in;
		ctl_nxt.found = ctl_in.found | do_lookup | do_inval;
	end

	// Token control register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q <= '0;
		end else begin
			ctl_q <= ctl_nxt;
		end
	end

	// Token payload; a lookup hit carries the stored frame onwards.
	always_ff @(posedge clk) begin
		tok_page_q   <= page_in;
		tok_frame_q  <= do_lookup ? frame_q : frame_in;
		tok_victim_q <= victim_in;
	end

	assign ctl_out    = ctl_q;
	assign page_out   = tok_page_q;
	assign frame_out  = tok_frame_q;
	assign victim_out = tok_victim_q;

endmodule

FILE: rtl/fully_associative_tlb_round_robin_top.sv
// Top level of the fully associative translation buffer with round-robin replacement.
// Builds the row of slot cells and keeps the victim pointer and the busy flag.
// Depends on tlbrr_pkg and tlbrr_cell.
//
//   Channel   Handshake             Fields
//   command   start / busy          cmd, page_number, frame_number, entry_valid
//   result    done (one cycle)      hit, frame_out
//
// An item walks down the row of ENTRIES cells, one cell per cycle; its result
// appears on done when it leaves the last cell, and busy is high until then,
// so the block takes no new item until the last one is through.
// Reset clears the valid marks, the victim pointer and all tokens in flight.
// The receiver cannot stall: each result is shown for exactly one cycle.
module fully_associative_tlb_round_robin_top #(
	parameter int ENTRIES    = tlbrr_pkg::DEF_ENTRIES,
	parameter int PAGE_BITS  = tlbrr_pkg::DEF_PAGE_BITS,
	parameter int FRAME_BITS = tlbrr_pkg::DEF_FRAME_BITS
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic [1:0]                       cmd,
	input  logic [tlbrr_pkg::IO_PAGE_W-1:0]  page_number,
	input  logic [tlbrr_pkg::IO_FRAME_W-1:0] frame_number,
	input  logic                             entry_valid,
	output logic                             done,
	output logic                             hit,
	output logic [tlbrr_pkg::IO_FRAME_W-1:0] frame_out
);
	import tlbrr_pkg::*;

	localparam int IDX_W  = $clog2(ENTRIES);
	localparam int PIN_W  = (PAGE_BITS < IO_PAGE_W) ? PAGE_BITS : IO_PAGE_W;
	localparam int FIN_W  = (FRAME_BITS < IO_FRAME_W) ? FRAME_BITS : IO_FRAME_W;

	tok_ctl_t              ctl_c    [ENTRIES+1];
	logic [PAGE_BITS-1:0]  page_c   [ENTRIES+1];
	logic [FRAME_BITS-1:0] frame_c  [ENTRIES+1];
	logic [IDX_W-1:0]      victim_c [ENTRIES+1];

	logic             busy_q;
	logic [IDX_W-1:0] victim_q;
	logic             accept;
	logic [ENTRIES-1:0] tok_vld;

	assign accept = start && !busy_q;
	assign busy   = busy_q;

	// Entry of the chain: the accepted item with its fields sized to the store.
	always_comb begin
		ctl_c[0]       = '0;
		ctl_c[0].vld   = accept;
		ctl_c[0].cmd   = cmd;
		ctl_c[0].mark  = entry_valid;
		ctl_c[0].found = 1'b0;
		page_c[0]      = PAGE_BITS'(page_number[PIN_W-1:0]);
		frame_c[0]     = FRAME_BITS'(frame_number[FIN_W-1:0]);
		victim_c[0]    = victim_q;
	end

	// The row of slot cells.
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		tlbrr_cell #(
			.PAGE_BITS (PAGE_BITS),
			.FRAME_BITS(FRAME_BITS),
			.IDX_W     (IDX_W),
			.INDEX     (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl_in    (ctl_c[i]),
			.page_in   (page_c[i]),
			.frame_in  (frame_c[i]),
			.victim_in (victim_c[i]),
			.ctl_out   (ctl_c[i+1]),
			.page_out  (page_c[i+1]),
			.frame_out (frame_c[i+1]),
			.victim_out(victim_c[i+1])
		);
		assign tok_vld[i] = ctl_c[i+1].vld;
	end

	// Busy from acceptance until the item leaves the last cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (accept) begin
			busy_q <= 1'b1;
		end else if (ctl_c[ENTRIES].vld) begin
			busy_q <= 1'b0;
		end
	end

	// Round-robin victim pointer, advanced when an insert is accepted.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			victim_q <= '0;
		end else if (accept && (cmd == CMD_INSERT)) begin
			if (victim_q == IDX_W'(ENTRIES - 1)) begin
				victim_q <= '0;
			end else begin
				victim_q <= victim_q + 1'b1;
			end
		end
	end

	// Result from the tail of the row; only a lookup reports a hit.
	always_comb begin
		done      = ctl_c[ENTRIES].vld;
		hit       = ctl_c[ENTRIES].vld && ctl_c[ENTRIES].found
			&& (ctl_c[ENTRIES].cmd == CMD_LOOKUP);
		frame_out = hit ? IO_FRAME_W'(frame_c[ENTRIES][FIN_W-1:0]) : '0;
	end

	// At most one item travels the row at a time.
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(tok_vld) <= 1)
		else $error("more than one item in the row of cells");

	// A result only leaves while the block is busy with that item.
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy_q)
		else $error("result without an item in flight");

	// An accepted item makes the block busy on the next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> busy_q)
		else $error("busy not raised after acceptance");

	// Only an insert moves the victim pointer.
	a_victim_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(accept && (cmd == CMD_INSERT)) |=> $stable(victim_q))
		else $error("victim pointer moved without an insert");

	// A hit is only ever shown together with the result strobe.
	a_hit_done: assert property (@(posedge clk) disable iff (!arst_n)
		hit |-> done)
		else $error("hit raised outside a result");

endmodule
